>>> rtl/core/mtep_pkg.sv
`timescale 1ns / 1ps
package mtep_pkg;

  localparam int unsigned EventLimitW = 24;
  localparam int unsigned TempoLimitW = 8;
  localparam logic [EventLimitW-1:0] EventLimitReset = 24'd4096;
  localparam logic [TempoLimitW-1:0] TempoLimitReset = 8'd64;
  localparam int unsigned DefaultQueueDepth = 2;

  // input operations
  typedef enum logic [1:0] {
    OP_START_FILE  = 2'd0,
    OP_START_TRACK = 2'd1,
    OP_DATA        = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic {
    REG_EVENT_LIMIT = 1'b0,
    REG_TEMPO_LIMIT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_DELTA     = 4'd1,
    PH_STATUS    = 4'd2,
    PH_META_TYPE = 4'd3,
    PH_META_LEN  = 4'd4,
    PH_SYSEX_LEN = 4'd5,
    PH_DATA1     = 4'd6,
    PH_DATA2     = 4'd7,
    PH_TEMPO     = 4'd8,
    PH_SKIP      = 4'd9,
    PH_DONE      = 4'd10
  } phase_e;

  localparam logic [7:0] ByteMeta     = 8'hFF;
  localparam logic [7:0] ByteSysex    = 8'hF0;
  localparam logic [7:0] ByteSysexEsc = 8'hF7;
  localparam logic [7:0] MetaTempo    = 8'h51;
  localparam logic [7:0] MetaEnd      = 8'h2F;
  localparam logic [3:0] TypeNoteOff  = 4'h8;
  localparam logic [3:0] TypeNoteOn   = 4'h9;
  localparam logic [3:0] TypeProgram  = 4'hC;
  localparam logic [3:0] TypePressure = 4'hD;

  // classified item passed from front to back
  typedef struct packed {
    op_e         op;
    logic [31:0] track_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] tick;
    logic [3:0]  message_type;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_us;
    logic        track_ended;
    logic        track_aborted;
  } result_t;

endpackage

>>> rtl/core/mtep_front.sv
`timescale 1ns / 1ps
module mtep_front
  import mtep_pkg::*;
#(
  parameter int unsigned Depth = DefaultQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t          mem_q [Depth];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           push, pop, keep;

  // drop unused operation codes here so the back sees only real work
  assign keep       = (in_item_i.op != OP_NONE);
  assign in_ready_o = (cnt_q != (AW+1)'(Depth));
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop) rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (AW+1)'(Depth)) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");
`endif
endmodule

>>> rtl/core/mtep_back.sv
`timescale 1ns / 1ps
module mtep_back
  import mtep_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  item_t                  q_item_i,
  input  logic [EventLimitW-1:0] event_limit_i,
  input  logic [TempoLimitW-1:0] tempo_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output result_t                out_res_o
);
  phase_e      ph_q, ph_d;
  logic [31:0] tick_q, tick_d, left_q, left_d;
  logic [7:0]  last_q, last_d, cur_q, cur_d, meta_q, meta_d;
  logic [27:0] vlq_q, vlq_d, skip_q, skip_d;
  logic [2:0]  vn_q, vn_d;
  logic [6:0]  held_q, held_d;
  logic [23:0] tmp_q, tmp_d;
  logic [23:0] ev_q, ev_d;
  logic [7:0]  tc_q, tc_d;
  logic        ov_q;
  result_t     res_q, r;
  logic        rv, take;

  logic [7:0]  b;
  logic [27:0] vnew;
  logic        vdone, vbad;
  logic [31:0] left_m1;

  // output register empties or is taken this cycle
  assign q_ready_o   = !ov_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;
  assign b       = q_item_i.data_byte;
  assign vnew    = {vlq_q[20:0], b[6:0]};
  assign vdone   = !b[7];
  assign vbad    = b[7] && (vn_q >= 3'd3);
  assign left_m1 = left_q - 32'd1;

  // per-word parser step
  always_comb begin
    logic [3:0] ty;
    logic       fin;
    logic [6:0] sec;
    logic       abrt;
    logic [1:0] n;
    ph_d = ph_q; tick_d = tick_q; left_d = left_q; last_d = last_q;
    cur_d = cur_q; meta_d = meta_q; vlq_d = vlq_q; skip_d = skip_q;
    vn_d = vn_q; held_d = held_q; tmp_d = tmp_q; ev_d = ev_q; tc_d = tc_q;
    r = '0; rv = 1'b0; fin = 1'b0; sec = '0; abrt = 1'b0; ty = '0; n = '0;
    if (take) begin
      case (q_item_i.op)
        OP_START_FILE: begin
          ev_d = '0; tc_d = '0; ph_d = PH_IDLE;
        end
        OP_START_TRACK: begin
          left_d = q_item_i.track_length;
          tick_d = '0; last_d = '0; cur_d = '0; held_d = '0; skip_d = '0;
          ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
          if (q_item_i.track_length == '0) begin
            ph_d = PH_DONE; rv = 1'b1; r.kind = KIND_STATUS; r.track_ended = 1'b1;
          end
        end
        OP_DATA: begin
          if (ph_q != PH_IDLE && ph_q != PH_DONE && left_q != '0) begin
            left_d = left_m1;
            case (ph_q)
              PH_DELTA: begin
                vlq_d = vnew; vn_d = vn_q + 3'd1;
                if (vdone) begin
                  tick_d = tick_q + {4'd0, vnew}; ph_d = PH_STATUS;
                end else if (vbad) abrt = 1'b1;
              end
              PH_STATUS: begin
                if (!b[7]) begin
                  if (last_q == '0) abrt = 1'b1;
                  else begin
                    cur_d = last_q; held_d = b[6:0];
                    if (last_q[7:4] == TypeProgram || last_q[7:4] == TypePressure)
                      fin = 1'b1;
                    else ph_d = PH_DATA2;
                  end
                end else if (b < 8'hF0) begin
                  last_d = b; cur_d = b; ph_d = PH_DATA1;
                end else if (b == ByteMeta) ph_d = PH_META_TYPE;
                else if (b == ByteSysex || b == ByteSysexEsc) begin
                  ph_d = PH_SYSEX_LEN; vlq_d = '0; vn_d = '0;
                end else if (b >= 8'hF1 && b <= 8'hF6) begin
                  last_d = '0;
                  n = (b == 8'hF2) ? 2'd2 : (b == 8'hF6) ? 2'd0 : 2'd1;
                  if (b == 8'hF4 || b == 8'hF5) abrt = 1'b1;
                  else if ({30'd0, n} > left_m1) abrt = 1'b1;
                  else if (n == 2'd0) begin
                    ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                  end else begin
                    skip_d = {26'd0, n}; ph_d = PH_SKIP;
                  end
                end else begin
                  ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                end
              end
              PH_META_TYPE: begin
                meta_d = b; ph_d = PH_META_LEN; vlq_d = '0; vn_d = '0;
              end
              PH_META_LEN, PH_SYSEX_LEN: begin
                vlq_d = vnew; vn_d = vn_q + 3'd1;
                if (vdone) begin
                  if ({4'd0, vnew} > left_m1) abrt = 1'b1;
                  else if (ph_q == PH_META_LEN && meta_q == MetaTempo && vnew == 28'd3) begin
                    tmp_d = '0; skip_d = 28'd3; ph_d = PH_TEMPO;
                  end else if (ph_q == PH_META_LEN && meta_q == MetaEnd) begin
                    ph_d = PH_DONE; rv = 1'b1; r.kind = KIND_STATUS;
                    r.track_ended = 1'b1;
                  end else if (vnew == '0) begin
                    ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                  end else begin
                    skip_d = vnew; ph_d = PH_SKIP;
                  end
                end else if (vbad) abrt = 1'b1;
              end
              PH_DATA1: begin
                if (b[7]) begin
                  ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                end else begin
                  held_d = b[6:0];
                  if (cur_q[7:4] == TypeProgram || cur_q[7:4] == TypePressure) fin = 1'b1;
                  else ph_d = PH_DATA2;
                end
              end
              PH_DATA2: begin
                if (b[7]) begin
                  ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                end else begin
                  fin = 1'b1; sec = b[6:0];
                end
              end
              PH_TEMPO: begin
                tmp_d = {tmp_q[15:0], b}; skip_d = skip_q - 28'd1;
                if (skip_q == 28'd1) begin
                  if (tc_q < tempo_limit_i) begin
                    tc_d = tc_q + 8'd1; rv = 1'b1; r.kind = KIND_TEMPO;
                    r.tempo_us = {tmp_q[15:0], b};
                  end
                  ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                end
              end
              PH_SKIP: begin
                skip_d = skip_q - 28'd1;
                if (skip_q == 28'd1) begin
                  ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
                end
              end
              default: ;
            endcase
            // channel message completion
            if (fin) begin
              ty = cur_d[7:4];
              if (ev_q >= event_limit_i) abrt = 1'b1;
              else begin
                ev_d = ev_q + 24'd1;
                if (ty == TypeNoteOn && sec == '0) ty = TypeNoteOff;
                rv = 1'b1; r.kind = KIND_CHANNEL; r.message_type = ty;
                r.channel = cur_d[3:0]; r.first_data = held_d; r.second_data = sec;
                ph_d = PH_DELTA; vlq_d = '0; vn_d = '0;
              end
            end
            // abort, or the last byte of the track
            if (abrt) begin
              ph_d = PH_DONE; rv = 1'b1; r = '0; r.kind = KIND_STATUS;
              r.track_aborted = 1'b1;
            end else if (ph_d != PH_DONE && left_m1 == '0) begin
              if (ph_d == PH_DELTA && vn_d == '0) begin
                ph_d = PH_DONE;
                if (!rv) begin
                  rv = 1'b1; r.kind = KIND_STATUS;
                end
                r.track_ended = 1'b1;
              end else begin
                ph_d = PH_DONE; rv = 1'b1; r = '0; r.kind = KIND_STATUS;
                r.track_aborted = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      r.tick = tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; tick_q <= '0; left_q <= '0; last_q <= '0; cur_q <= '0;
      meta_q <= '0; vlq_q <= '0; skip_q <= '0; vn_q <= '0; held_q <= '0;
      tmp_q <= '0; ev_q <= '0; tc_q <= '0; ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d; tick_q <= tick_d; left_q <= left_d; last_q <= last_d;
      cur_q <= cur_d; meta_q <= meta_d; vlq_q <= vlq_d; skip_q <= skip_d;
      vn_q <= vn_d; held_q <= held_d; tmp_q <= tmp_d; ev_q <= ev_d; tc_q <= tc_d;
      if (take) ov_q <= rv;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take && rv) res_q <= r;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(res_q))) else $error("result lost");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(res_q.track_ended && res_q.track_aborted)) else $error("both flags");
  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rv && (r.track_ended || r.track_aborted)) |=> (ph_q == PH_DONE))
    else $error("flag without done");
`endif
endmodule

>>> rtl/core/midi_track_event_parser_core.sv
`timescale 1ns / 1ps
// channel  | dir | handshake                    | contents
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser operation; tdata track_length, data_byte
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser kind; tlast track_ended; tdata event
// cfg      | in  | cfg_we_i                     | event_limit (0), tempo_limit (1)
// one word per cycle while m_axis is not stalled: a queue of QueueDepth entries (two by default)
// feeds a combinational parser step, and the result register is refilled in the same cycle it is taken.
// a result passes through the queue and then the result register before it appears on m_axis.
// reset clears parser state, counts and limits to their defaults.
// a stalled output stalls the parser; the queue keeps taking input until full.
module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // operation[1:0]
  input  logic [39:0]  s_axis_tdata,  // track_length[31:0], data_byte[39:32]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,  // kind[1:0]
  output logic         m_axis_tlast,
  output logic [79:0]  m_axis_tdata,  // tick[31:0], message_type[35:32], channel[39:36],
                                      // first_data[46:40], second_data[53:47],
                                      // tempo_us[77:54], track_aborted[78]
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [23:0]  cfg_data_i
);
  logic [EventLimitW-1:0] ev_lim_q;
  logic [TempoLimitW-1:0] tp_lim_q;
  item_t   in_item, q_item;
  logic    q_valid, q_ready;
  result_t res;

  assign in_item.op           = op_e'(s_axis_tuser);
  assign in_item.track_length = s_axis_tdata[31:0];
  assign in_item.data_byte    = s_axis_tdata[39:32];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_lim_q <= EventLimitReset;
      tp_lim_q <= TempoLimitReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_EVENT_LIMIT) ev_lim_q <= cfg_data_i;
      else tp_lim_q <= cfg_data_i[TempoLimitW-1:0];
    end
  end

  mtep_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready), .in_item_i (in_item),
    .q_valid_o (q_valid), .q_ready_i (q_ready), .q_item_o (q_item)
  );

  mtep_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_ready_o (q_ready), .q_item_i (q_item),
    .event_limit_i (ev_lim_q), .tempo_limit_i (tp_lim_q),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready), .out_res_o (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.track_ended;
  assign m_axis_tdata = {1'b0, res.track_aborted, res.tempo_us,
                         res.second_data, res.first_data, res.channel,
                         res.message_type, res.tick};
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mtep_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [23:0] cfg_data_i = '0;

  midi_track_event_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // pending input words and parsed events still owed by the block
  item_t   pend_q[$];
  result_t parsed_q[$];
  item_t   cur_item;
  logic [7:0] body_q[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // parser copy kept by the bench
  phase_e      ph;
  logic [31:0] tick_sum;
  logic [7:0]  run_status;
  logic [31:0] remain;
  logic [27:0] vlq_acc;
  logic [2:0]  vlq_cnt;
  logic [7:0]  meta_code;
  logic [7:0]  cur_status;
  logic [6:0]  data_hold;
  logic [23:0] tempo_acc;
  logic [27:0] skip_cnt;
  logic [23:0] evt_cnt;
  logic [7:0]  tempo_cnt;
  logic [23:0] lim_events;
  logic [7:0]  lim_tempos;
  result_t     res;
  bit          have_res;

  function automatic void go_delta();
    ph = PH_DELTA;
    vlq_acc = '0;
    vlq_cnt = '0;
  endfunction

  function automatic void abort_track();
    ph = PH_DONE;
    have_res = 1'b1;
    res.kind = KIND_STATUS;
    res.track_aborted = 1'b1;
  endfunction

  function automatic void end_track();
    ph = PH_DONE;
    if (!have_res) begin
      have_res = 1'b1;
      res.kind = KIND_STATUS;
    end
    res.track_ended = 1'b1;
  endfunction

  // 1 complete, 0 more to come, -1 overlong
  function automatic int vlq_in(logic [7:0] b);
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    vlq_cnt = vlq_cnt + 3'd1;
    if (!b[7]) return 1;
    if (vlq_cnt >= 3'd4) begin
      abort_track();
      return -1;
    end
    return 0;
  endfunction

  task automatic skip_then_delta(logic [27:0] n);
    if (n == '0) begin
      go_delta();
    end else begin
      skip_cnt = n;
      ph = PH_SKIP;
    end
  endtask

  task automatic finish_msg(logic [6:0] second);
    logic [3:0] mtype;
    mtype = cur_status[7:4];
    if (evt_cnt >= lim_events) begin
      abort_track();
      return;
    end
    evt_cnt = evt_cnt + 24'd1;
    if (mtype == TypeNoteOn && second == '0) mtype = TypeNoteOff;
    have_res = 1'b1;
    res.kind = KIND_CHANNEL;
    res.message_type = mtype;
    res.channel = cur_status[3:0];
    res.first_data = data_hold;
    res.second_data = second;
    go_delta();
  endtask

  task automatic first_data_in(logic [7:0] b);
    if (b[7]) begin
      go_delta();
      return;
    end
    data_hold = b[6:0];
    if (cur_status[7:4] == TypeProgram || cur_status[7:4] == TypePressure) finish_msg('0);
    else ph = PH_DATA2;
  endtask

  task automatic status_in(logic [7:0] b);
    logic [27:0] n;
    if (b < 8'h80) begin
      if (run_status == '0) begin
        abort_track();
        return;
      end
      cur_status = run_status;
      first_data_in(b);
    end else if (b < 8'hF0) begin
      run_status = b;
      cur_status = b;
      ph = PH_DATA1;
    end else if (b == ByteMeta) begin
      ph = PH_META_TYPE;
    end else if (b == ByteSysex || b == ByteSysexEsc) begin
      go_delta();
      ph = PH_SYSEX_LEN;
    end else if (b >= 8'hF1 && b <= 8'hF6) begin
      run_status = '0;
      if (b == 8'hF4 || b == 8'hF5) begin
        abort_track();
        return;
      end
      n = (b == 8'hF2) ? 28'd2 : (b == 8'hF6) ? 28'd0 : 28'd1;
      if (32'(n) > remain) begin
        abort_track();
        return;
      end
      skip_then_delta(n);
    end else begin
      go_delta();
    end
  endtask

  task automatic byte_in(logic [7:0] b);
    case (ph)
      PH_DELTA: begin
        if (vlq_in(b) == 1) begin
          tick_sum = tick_sum + 32'(vlq_acc);
          ph = PH_STATUS;
        end
      end
      PH_STATUS: status_in(b);
      PH_META_TYPE: begin
        meta_code = b;
        go_delta();
        ph = PH_META_LEN;
      end
      PH_META_LEN: begin
        if (vlq_in(b) == 1) begin
          if (32'(vlq_acc) > remain) abort_track();
          else if (meta_code == MetaTempo && vlq_acc == 28'd3) begin
            tempo_acc = '0;
            skip_cnt = 28'd3;
            ph = PH_TEMPO;
          end else if (meta_code == MetaEnd) end_track();
          else skip_then_delta(vlq_acc);
        end
      end
      PH_SYSEX_LEN: begin
        if (vlq_in(b) == 1) begin
          if (32'(vlq_acc) > remain) abort_track();
          else skip_then_delta(vlq_acc);
        end
      end
      PH_DATA1: first_data_in(b);
      PH_DATA2: begin
        if (b[7]) go_delta();
        else finish_msg(b[6:0]);
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        skip_cnt = skip_cnt - 28'd1;
        if (skip_cnt == '0) begin
          if (tempo_cnt < lim_tempos) begin
            tempo_cnt = tempo_cnt + 8'd1;
            have_res = 1'b1;
            res.kind = KIND_TEMPO;
            res.tempo_us = tempo_acc;
          end
          go_delta();
        end
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 28'd1;
        if (skip_cnt == '0) go_delta();
      end
      default: ;
    endcase
  endtask

  // advance the parser copy by one accepted word, queue its event if any
  task automatic parse_word(item_t it);
    res = '0;
    have_res = 1'b0;
    case (it.op)
      OP_START_FILE: begin
        evt_cnt = '0;
        tempo_cnt = '0;
        ph = PH_IDLE;
      end
      OP_START_TRACK: begin
        remain = it.track_length;
        tick_sum = '0;
        run_status = '0;
        cur_status = '0;
        data_hold = '0;
        skip_cnt = '0;
        go_delta();
        if (remain == '0) end_track();
      end
      OP_DATA: begin
        if (ph != PH_IDLE && ph != PH_DONE && remain != '0) begin
          remain = remain - 32'd1;
          byte_in(it.data_byte);
          if (ph != PH_DONE && remain == '0) begin
            if (ph == PH_DELTA && vlq_cnt == '0) end_track();
            else abort_track();
          end
        end
      end
      default: ;
    endcase
    if (have_res) begin
      res.tick = tick_sum;
      parsed_q.push_back(res);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser <= '0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_word(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_item = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_item.op;
          s_axis_tdata <= {cur_item.data_byte, cur_item.track_length};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.tick = m_axis_tdata[31:0];
        got.message_type = m_axis_tdata[35:32];
        got.channel = m_axis_tdata[39:36];
        got.first_data = m_axis_tdata[46:40];
        got.second_data = m_axis_tdata[53:47];
        got.tempo_us = m_axis_tdata[77:54];
        got.track_ended = m_axis_tlast;
        got.track_aborted = m_axis_tdata[78];
        if (parsed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %p", got);
        end else begin
          want = parsed_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[midi_track_event_parser_core] ERROR");
      $finish;
    end
  end

  task automatic put(op_e op, logic [31:0] len, logic [7:0] b);
    item_t it;
    it.op = op;
    it.track_length = len;
    it.data_byte = b;
    pend_q.push_back(it);
  endtask

  task automatic put_vlq(logic [27:0] v);
    int n;
    n = (v >= 28'h200000) ? 4 : (v >= 28'h4000) ? 3 : (v >= 28'h80) ? 2 : 1;
    for (int i = n - 1; i >= 0; i--) body_q.push_back({(i != 0), 7'(v >> (7 * i))});
  endtask

  // one track built from well-formed events with rare breakage
  task automatic gen_track();
    int nev;
    int pick;
    int len;
    logic [3:0] mtype;
    body_q.delete();
    nev = $urandom_range(8, 1);
    for (int e = 0; e < nev; e++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        repeat (4) body_q.push_back(8'h80 | 8'($urandom_range(127)));
      end else if (pick < 50) begin
        put_vlq(28'd0);
      end else if (pick < 80) begin
        put_vlq(28'($urandom_range(127)));
      end else begin
        put_vlq(28'($urandom) >> $urandom_range(27));
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        mtype = 4'($urandom_range(14, 8));
        if (pick >= 30) begin
          // running status, sometimes without one set
          if (body_q.size() < 3 && $urandom_range(3) != 0) body_q.push_back(8'h90);
        end else begin
          body_q.push_back({mtype, 4'($urandom_range(15))});
        end
        body_q.push_back(8'($urandom_range(127)));
        if ($urandom_range(19) == 0) body_q.push_back(8'($urandom_range(255, 128)));
        else if ($urandom_range(4) == 0) body_q.push_back(8'd0);
        else body_q.push_back(8'($urandom_range(127)));
      end else if (pick < 58) begin
        body_q.push_back(ByteMeta);
        body_q.push_back(MetaTempo);
        body_q.push_back(8'd3);
        repeat (3) body_q.push_back(8'($urandom));
      end else if (pick < 66) begin
        body_q.push_back(ByteMeta);
        body_q.push_back(($urandom_range(3) == 0) ? MetaTempo : 8'($urandom_range(127)));
        len = $urandom_range(4);
        put_vlq(28'(len));
        repeat (len) body_q.push_back(8'($urandom));
      end else if (pick < 74) begin
        body_q.push_back($urandom_range(1) ? ByteSysex : ByteSysexEsc);
        len = $urandom_range(3);
        if ($urandom_range(9) == 0) len = 200;
        put_vlq(28'(len));
        if (len < 200) repeat (len) body_q.push_back(8'($urandom));
      end else if (pick < 82) begin
        body_q.push_back(8'($urandom_range(8'hF6, 8'hF1)));
        repeat ($urandom_range(2)) body_q.push_back(8'($urandom_range(127)));
      end else if (pick < 88) begin
        body_q.push_back(8'($urandom_range(8'hFE, 8'hF8)));
      end else if (pick < 94) begin
        body_q.push_back(8'($urandom));
      end else begin
        body_q.push_back(ByteMeta);
        body_q.push_back(MetaEnd);
        body_q.push_back(8'd0);
        repeat ($urandom_range(3)) body_q.push_back(8'($urandom));
      end
    end
    pick = $urandom_range(99);
    len = body_q.size();
    if (pick < 8) len = $urandom_range(body_q.size());
    else if (pick < 12) len = body_q.size() + $urandom_range(3, 1);
    if (pick >= 97) put(OP_START_TRACK, $urandom, 8'($urandom));
    else put(OP_START_TRACK, 32'(len), 8'($urandom));
    foreach (body_q[i]) put(OP_DATA, 32'($urandom), body_q[i]);
    if ($urandom_range(9) == 0) put(OP_DATA, 32'($urandom), 8'($urandom));
    if ($urandom_range(29) == 0) put(OP_NONE, 32'($urandom), 8'($urandom));
  endtask

  task automatic gen_random(int unsigned count);
    int unsigned target;
    target = pend_q.size() + count;
    while (pend_q.size() < target) begin
      put(OP_START_FILE, 32'($urandom), 8'($urandom));
      repeat ($urandom_range(4, 1)) gen_track();
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || s_axis_tvalid || parsed_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limits(logic [23:0] ev, logic [7:0] tp);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_EVENT_LIMIT;
    cfg_data_i <= ev;
    lim_events = ev;
    @(posedge clk_i);
    cfg_index_i <= REG_TEMPO_LIMIT;
    cfg_data_i <= {16'd0, tp};
    lim_tempos = tp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    ph = PH_IDLE;
    tick_sum = '0;
    run_status = '0;
    remain = '0;
    vlq_acc = '0;
    vlq_cnt = '0;
    meta_code = '0;
    cur_status = '0;
    data_hold = '0;
    tempo_acc = '0;
    skip_cnt = '0;
    evt_cnt = '0;
    tempo_cnt = '0;
    lim_events = EventLimitReset;
    lim_tempos = TempoLimitReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: stray words, empty track, field extremes, tempo and end of track
    put(OP_NONE, 32'hFFFF_FFFF, 8'hFF);
    put(OP_DATA, '0, 8'h90);
    put(OP_START_FILE, '0, '0);
    put(OP_START_TRACK, '0, '0);
    body_q = '{8'h00, 8'h90, 8'h3C, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'h7F,
               8'h00, 8'hC5, 8'h7F, 8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
               8'h00, 8'hFF, 8'h2F, 8'h00, 8'h00};
    put(OP_START_TRACK, 32'd25, '0);
    foreach (body_q[i]) put(OP_DATA, '0, body_q[i]);
    put(OP_START_TRACK, 32'hFFFF_FFFF, '0);
    put(OP_DATA, '0, 8'h00);
    put(OP_DATA, '0, 8'h55);
    put(OP_START_TRACK, 32'd9, '0);
    put(OP_DATA, '0, 8'h81);
    put(OP_START_TRACK, 32'd4, '0);
    put(OP_DATA, '0, 8'hFF);
    put(OP_DATA, '0, 8'hFF);
    put(OP_DATA, '0, 8'hFF);
    put(OP_DATA, '0, 8'hFF);
    wait_quiet();

    write_limits(24'd3, 8'd0);
    send_idle = 23;
    recv_idle = 53;
    gen_random(400);
    wait_quiet();

    write_limits(24'hFF_FFFF, 8'hFF);
    send_idle = 53;
    recv_idle = 23;
    gen_random(400);
    wait_quiet();

    write_limits(24'd0, 8'd1);
    send_idle = 0;
    recv_idle = 0;
    gen_random(150);
    wait_quiet();

    write_limits(24'd40, 8'd5);
    gen_random(550);
    wait_quiet();

    if (errors == 0) begin
      $display("[midi_track_event_parser_core] OK");
    end else begin
      $display("[midi_track_event_parser_core] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mtep_pkg.sv
rtl/core/mtep_front.sv
rtl/core/mtep_back.sv
rtl/core/midi_track_event_parser_core.sv
verif/tb_top.sv
